/* design/global_motion_type_decider_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the global motion type decider
// Shared property forms used by the design's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef GLOBAL_MOTION_TYPE_DECIDER_CORE_ASSERT_SVH
`define GLOBAL_MOTION_TYPE_DECIDER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GMTD_ASSERT_IMPL(lbl, clk_sig, rst_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
		else $error("gmtd: same-cycle check failed");

// next-cycle implication, disabled during reset
`define GMTD_ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
		else $error("gmtd: next-cycle check failed");

`endif

/* design/gmtd_pkg.sv */
// ----------------------------------------------------------------------------
// gmtd_pkg
// Types, widths and codes shared by the global motion type decider.
// ----------------------------------------------------------------------------
package gmtd_pkg;

	localparam int VECTOR_BITS     = 16;
	localparam int MAX_MACROBLOCKS = 65536;
	localparam int BLOCKS_PER_MB   = 16;

	localparam int SUM_W  = VECTOR_BITS + 5;
	localparam int MEAN_W = SUM_W;
	localparam int DIFF_W = SUM_W + 1;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int DIST_W = SQ_W + 1;
	localparam int SH_W   = 3;

	localparam int PU_CNT_W  = 5;
	localparam int MB_CNT_W  = $clog2(MAX_MACROBLOCKS + 1);
	localparam int BLK_CNT_W = $clog2(BLOCKS_PER_MB * MAX_MACROBLOCKS + 1);

	localparam logic [PU_CNT_W-1:0]  PU_CNT_MAX  = {PU_CNT_W{1'b1}};
	localparam logic [MB_CNT_W-1:0]  MB_CNT_MAX  = MB_CNT_W'(MAX_MACROBLOCKS);
	localparam logic [BLK_CNT_W-1:0] BLK_CNT_MAX = BLK_CNT_W'(BLOCKS_PER_MB * MAX_MACROBLOCKS);

	localparam int THR_W     = 16;
	localparam int RATIO_W   = 8;
	localparam int PROD_W    = BLK_CNT_W + RATIO_W;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = THR_W;

	localparam logic [THR_W-1:0]   THR_RESET   = 16'd16;
	localparam logic               BY_MB_RESET = 1'b1;
	localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd9;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_INTRA = 2'd0,
		MODE_REF1  = 2'd1,
		MODE_REF2  = 2'd2,
		MODE_BOTH  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		BND_INSIDE = 2'd0,
		BND_PU     = 2'd1,
		BND_MB     = 2'd2,
		BND_FRAME  = 2'd3
	} bnd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_BY_MB     = 2'd1,
		CFG_RATIO     = 2'd2
	} cfg_idx_t;

	// one finished PU handed from front to back
	typedef struct packed {
		logic [3:0][SUM_W-1:0]       sums;
		logic [3:0][VECTOR_BITS-1:0] loc;
		mode_t                       mode;
		logic [SH_W-1:0]             sh;
		bnd_t                        bnd;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic [THR_W-1:0]   thr;
		logic               by_mb;
		logic [RATIO_W-1:0] ratio;
	} cfg_t;

	typedef struct packed {
		logic pu_inter;
		logic pu_use_global;
		logic mb_valid;
		logic mb_use_global;
		logic frame_valid;
		logic frame_use_global;
		logic frame_global_only;
	} res_t;

endpackage

/* design/gmtd_front.sv */
// ----------------------------------------------------------------------------
// gmtd_front
// Accepts block words, sums global vectors per PU and queues finished PUs.
// ----------------------------------------------------------------------------
module gmtd_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          pu_mode,
	input  logic [1:0]                          pu_depth,
	input  logic [gmtd_pkg::VECTOR_BITS-1:0]    local1_x,
	input  logic [gmtd_pkg::VECTOR_BITS-1:0]    local1_y,
	input  logic [gmtd_pkg::VECTOR_BITS-1:0]    local2_x,
	input  logic [gmtd_pkg::VECTOR_BITS-1:0]    local2_y,
	input  logic [gmtd_pkg::VECTOR_BITS-1:0]    glob1_x,
	input  logic [gmtd_pkg::VECTOR_BITS-1:0]    glob1_y,
	input  logic [gmtd_pkg::VECTOR_BITS-1:0]    glob2_x,
	input  logic [gmtd_pkg::VECTOR_BITS-1:0]    glob2_y,
	input  logic [1:0]                          boundary,
	input  gmtd_pkg::q_status_t                 qs,
	output logic                                push,
	output gmtd_pkg::entry_t                    push_entry
);

	logic [3:0][gmtd_pkg::SUM_W-1:0]       sums_q;
	logic [3:0][gmtd_pkg::SUM_W-1:0]       sums_n;
	logic [3:0][gmtd_pkg::VECTOR_BITS-1:0] glob_in;
	logic [1:0]                            depth_cl;
	logic                                  accept;
	gmtd_pkg::bnd_t                        bnd;

	assign glob_in  = {glob2_y, glob2_x, glob1_y, glob1_x};
	assign bnd      = gmtd_pkg::bnd_t'(boundary);
	assign in_ready = !qs.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (bnd != gmtd_pkg::BND_INSIDE);

	// split depth three behaves as depth two
	assign depth_cl = (pu_depth > 2'd2) ? 2'd2 : pu_depth;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sums_n[k] = sums_q[k] + gmtd_pkg::SUM_W'($signed(glob_in[k]));
		end
	end

	always_comb begin
		push_entry.sums = sums_n;
		push_entry.loc  = {local2_y, local2_x, local1_y, local1_x};
		push_entry.mode = gmtd_pkg::mode_t'(pu_mode);
		push_entry.sh   = {2'd2 - depth_cl, 1'b0};
		push_entry.bnd  = bnd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q <= '0;
		end else if (accept) begin
			sums_q <= (bnd != gmtd_pkg::BND_INSIDE) ? '0 : sums_n;
		end
	end

endmodule

/* design/gmtd_queue.sv */
// ----------------------------------------------------------------------------
// gmtd_queue
// Small FIFO of finished PUs between the front and the back.
// ----------------------------------------------------------------------------
`include "global_motion_type_decider_core_assert.svh"

module gmtd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gmtd_pkg::entry_t    push_entry,
	input  logic                pop,
	output gmtd_pkg::entry_t    head,
	output gmtd_pkg::q_status_t qs
);

	gmtd_pkg::entry_t                 mem_q [gmtd_pkg::QUEUE_DEPTH];
	logic [gmtd_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [gmtd_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [gmtd_pkg::QCNT_W-1:0]      cnt_q;

	localparam logic [gmtd_pkg::QPTR_W-1:0] PTR_LAST = gmtd_pkg::QPTR_W'(gmtd_pkg::QUEUE_DEPTH - 1);
	localparam logic [gmtd_pkg::QCNT_W-1:0] CNT_FULL = gmtd_pkg::QCNT_W'(gmtd_pkg::QUEUE_DEPTH);

	assign head     = mem_q[rd_ptr_q];
	assign qs.full  = (cnt_q == CNT_FULL);
	assign qs.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`GMTD_ASSERT_IMPL(a_q_no_overflow, clk, arst_n, push, !qs.full)
	`GMTD_ASSERT_IMPL(a_q_no_underflow, clk, arst_n, pop, !qs.empty)
	`GMTD_ASSERT_IMPL(a_q_cnt_range, clk, arst_n, 1'b1, cnt_q <= CNT_FULL)

endmodule

/* design/gmtd_back.sv */
// ----------------------------------------------------------------------------
// gmtd_back
// PU distance test, macroblock and frame counting, frame verdict.
// ----------------------------------------------------------------------------
`include "global_motion_type_decider_core_assert.svh"

module gmtd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  gmtd_pkg::cfg_t      cfg,
	input  gmtd_pkg::entry_t    head,
	input  gmtd_pkg::q_status_t qs,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output gmtd_pkg::res_t      res
);

	typedef struct packed {
		logic [3:0][gmtd_pkg::MEAN_W-1:0]      mean;
		logic [3:0][gmtd_pkg::VECTOR_BITS-1:0] loc;
		gmtd_pkg::mode_t                       mode;
		logic [gmtd_pkg::SH_W-1:0]             sh;
		gmtd_pkg::bnd_t                        bnd;
	} st1_t;

	typedef struct packed {
		logic [3:0][gmtd_pkg::DIFF_W-1:0] dif;
		gmtd_pkg::mode_t                  mode;
		logic [gmtd_pkg::SH_W-1:0]        sh;
		gmtd_pkg::bnd_t                   bnd;
	} st2_t;

	typedef struct packed {
		logic [3:0][gmtd_pkg::SQ_W-1:0] sq;
		gmtd_pkg::mode_t                mode;
		logic [gmtd_pkg::SH_W-1:0]      sh;
		gmtd_pkg::bnd_t                 bnd;
	} st3_t;

	typedef struct packed {
		logic                      ok1;
		logic                      ok2;
		gmtd_pkg::mode_t           mode;
		logic [gmtd_pkg::SH_W-1:0] sh;
		gmtd_pkg::bnd_t            bnd;
	} st4_t;

	typedef struct packed {
		logic                           pu_inter;
		logic                           pu_g;
		logic                           mb_valid;
		logic                           mb_g;
		logic                           frame_valid;
		logic [gmtd_pkg::BLK_CNT_W-1:0] g;
		logic [gmtd_pkg::BLK_CNT_W-1:0] l;
	} st5_t;

	typedef struct packed {
		st5_t                        base;
		logic [gmtd_pkg::PROD_W-1:0] prod;
	} st6_t;

	function automatic logic [gmtd_pkg::MEAN_W-1:0] round_mean(
		input logic [gmtd_pkg::SUM_W-1:0] s,
		input logic [gmtd_pkg::SH_W-1:0]  sh
	);
		logic signed [gmtd_pkg::SUM_W:0] ext;
		logic signed [gmtd_pkg::SUM_W:0] half;
		logic signed [gmtd_pkg::SUM_W:0] r;
		ext  = (gmtd_pkg::SUM_W + 1)'($signed(s));
		half = $signed((gmtd_pkg::SUM_W + 1)'(1) << (sh - 1'b1));
		if (sh == '0) begin
			r = ext;
		end else begin
			r = ext + half;
			r = r >>> sh;
		end
		return r[gmtd_pkg::MEAN_W-1:0];
	endfunction

	st1_t s1_s1;
	st2_t s2_s2;
	st3_t s3_s3;
	st4_t s4_s4;
	st5_t s5_s5;
	st6_t s6_s6;
	gmtd_pkg::res_t res_s7;
	logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
	logic en;

	logic [gmtd_pkg::PU_CNT_W-1:0]  mbg_q, mbl_q, mbg_n, mbl_n;
	logic [gmtd_pkg::MB_CNT_W-1:0]  fmg_q, fml_q, fmg_n, fml_n;
	logic [gmtd_pkg::BLK_CNT_W-1:0] fbg_q, fbl_q, fbg_n, fbl_n;
	logic [gmtd_pkg::BLK_CNT_W:0]   blk_sum;
	logic [gmtd_pkg::BLK_CNT_W-1:0] blk_base;
	logic [gmtd_pkg::BLK_CNT_W-1:0] blk_sat;
	logic [gmtd_pkg::BLK_CNT_W-1:0] blocks;
	logic inter, pu_g, mb_end, frame_end, mb_any, mb_g;

	logic [3:0][gmtd_pkg::MEAN_W-1:0] mean_c;
	logic [3:0][gmtd_pkg::DIFF_W-1:0] dif_c;
	logic [3:0][gmtd_pkg::SQ_W-1:0]   sq_c;
	logic [gmtd_pkg::DIST_W-1:0]      dist1, dist2;
	logic [gmtd_pkg::PROD_W-1:0]      g_ext;

	// whole back pipeline moves together, output register at the end
	assign en        = !v7_q || out_ready;
	assign pop       = en && !qs.empty;
	assign out_valid = v7_q;
	assign res       = res_s7;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			mean_c[k] = round_mean(head.sums[k], head.sh);
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			dif_c[k] = $signed(gmtd_pkg::DIFF_W'($signed(s1_s1.loc[k])))
				- $signed(gmtd_pkg::DIFF_W'($signed(s1_s1.mean[k])));
		end
	end

	always_comb begin
		logic signed [gmtd_pkg::SQ_W-1:0] p;
		for (int k = 0; k < 4; k++) begin
			p = $signed(s2_s2.dif[k]) * $signed(s2_s2.dif[k]);
			sq_c[k] = p;
		end
	end

	assign dist1 = {1'b0, s3_s3.sq[0]} + {1'b0, s3_s3.sq[1]};
	assign dist2 = {1'b0, s3_s3.sq[2]} + {1'b0, s3_s3.sq[3]};

	// counter update for the PU leaving stage four
	always_comb begin
		inter = (s4_s4.mode != gmtd_pkg::MODE_INTRA);
		pu_g  = 1'b0;
		unique case (s4_s4.mode)
			gmtd_pkg::MODE_INTRA: pu_g = 1'b0;
			gmtd_pkg::MODE_REF1:  pu_g = s4_s4.ok1;
			gmtd_pkg::MODE_REF2:  pu_g = s4_s4.ok2;
			gmtd_pkg::MODE_BOTH:  pu_g = s4_s4.ok1 && s4_s4.ok2;
		endcase
		mb_end    = (s4_s4.bnd == gmtd_pkg::BND_MB) || (s4_s4.bnd == gmtd_pkg::BND_FRAME);
		frame_end = (s4_s4.bnd == gmtd_pkg::BND_FRAME);
		blocks    = gmtd_pkg::BLK_CNT_W'(1) << s4_s4.sh;

		mbg_n = mbg_q;
		mbl_n = mbl_q;
		if (inter && pu_g && (mbg_q != gmtd_pkg::PU_CNT_MAX)) begin
			mbg_n = mbg_q + 1'b1;
		end
		if (inter && !pu_g && (mbl_q != gmtd_pkg::PU_CNT_MAX)) begin
			mbl_n = mbl_q + 1'b1;
		end

		blk_base = pu_g ? fbg_q : fbl_q;
		blk_sum  = {1'b0, blk_base} + {1'b0, blocks};
		blk_sat  = (blk_sum > {1'b0, gmtd_pkg::BLK_CNT_MAX}) ? gmtd_pkg::BLK_CNT_MAX
			: blk_sum[gmtd_pkg::BLK_CNT_W-1:0];
		fbg_n = (inter && pu_g) ? blk_sat : fbg_q;
		fbl_n = (inter && !pu_g) ? blk_sat : fbl_q;

		mb_any = (mbg_n != '0) || (mbl_n != '0);
		mb_g   = mb_any && (mbl_n == '0);
		fmg_n  = fmg_q;
		fml_n  = fml_q;
		if (mb_end && mb_g && (fmg_q != gmtd_pkg::MB_CNT_MAX)) begin
			fmg_n = fmg_q + 1'b1;
		end
		if (mb_end && mb_any && !mb_g && (fml_q != gmtd_pkg::MB_CNT_MAX)) begin
			fml_n = fml_q + 1'b1;
		end
	end

	assign g_ext = gmtd_pkg::PROD_W'(s6_s6.base.g);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
			v6_q <= 1'b0;
			v7_q <= 1'b0;
		end else if (en) begin
			v1_q <= !qs.empty;
			v2_q <= v1_q;
			v3_q <= v2_q;
			v4_q <= v3_q;
			v5_q <= v4_q;
			v6_q <= v5_q;
			v7_q <= v6_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbg_q <= '0;
			mbl_q <= '0;
			fmg_q <= '0;
			fml_q <= '0;
			fbg_q <= '0;
			fbl_q <= '0;
		end else if (en && v4_q) begin
			mbg_q <= mb_end ? '0 : mbg_n;
			mbl_q <= mb_end ? '0 : mbl_n;
			fmg_q <= frame_end ? '0 : fmg_n;
			fml_q <= frame_end ? '0 : fml_n;
			fbg_q <= frame_end ? '0 : fbg_n;
			fbl_q <= frame_end ? '0 : fbl_n;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s1_s1.mean <= mean_c;
			s1_s1.loc  <= head.loc;
			s1_s1.mode <= head.mode;
			s1_s1.sh   <= head.sh;
			s1_s1.bnd  <= head.bnd;

			s2_s2.dif  <= dif_c;
			s2_s2.mode <= s1_s1.mode;
			s2_s2.sh   <= s1_s1.sh;
			s2_s2.bnd  <= s1_s1.bnd;

			s3_s3.sq   <= sq_c;
			s3_s3.mode <= s2_s2.mode;
			s3_s3.sh   <= s2_s2.sh;
			s3_s3.bnd  <= s2_s2.bnd;

			s4_s4.ok1  <= dist1 <= gmtd_pkg::DIST_W'(cfg.thr);
			s4_s4.ok2  <= dist2 <= gmtd_pkg::DIST_W'(cfg.thr);
			s4_s4.mode <= s3_s3.mode;
			s4_s4.sh   <= s3_s3.sh;
			s4_s4.bnd  <= s3_s3.bnd;

			s5_s5.pu_inter    <= inter;
			s5_s5.pu_g        <= inter && pu_g;
			s5_s5.mb_valid    <= mb_end && mb_any;
			s5_s5.mb_g        <= mb_end && mb_g;
			s5_s5.frame_valid <= frame_end;
			s5_s5.g <= cfg.by_mb ? gmtd_pkg::BLK_CNT_W'(fmg_n) : fbg_n;
			s5_s5.l <= cfg.by_mb ? gmtd_pkg::BLK_CNT_W'(fml_n) : fbl_n;

			s6_s6.base <= s5_s5;
			s6_s6.prod <= gmtd_pkg::PROD_W'(s5_s5.l) * gmtd_pkg::PROD_W'(cfg.ratio);

			res_s7.pu_inter      <= s6_s6.base.pu_inter;
			res_s7.pu_use_global <= s6_s6.base.pu_g;
			res_s7.mb_valid      <= s6_s6.base.mb_valid;
			res_s7.mb_use_global <= s6_s6.base.mb_g;
			res_s7.frame_valid   <= s6_s6.base.frame_valid;
			res_s7.frame_use_global <= s6_s6.base.frame_valid
				&& !(s6_s6.base.g < s6_s6.base.l);
			res_s7.frame_global_only <= s6_s6.base.frame_valid
				&& !(s6_s6.base.g < s6_s6.base.l) && (g_ext > s6_s6.prod);
		end
	end

	`GMTD_ASSERT_NEXT(a_frame_clear, clk, arst_n,
		en && v4_q && (s4_s4.bnd == gmtd_pkg::BND_FRAME),
		(fmg_q == '0) && (fml_q == '0) && (fbg_q == '0) && (fbl_q == '0))
	`GMTD_ASSERT_NEXT(a_mb_clear, clk, arst_n,
		en && v4_q && (s4_s4.bnd != gmtd_pkg::BND_PU),
		(mbg_q == '0) && (mbl_q == '0))
	`GMTD_ASSERT_IMPL(a_only_needs_use, clk, arst_n,
		v7_q && res_s7.frame_global_only,
		res_s7.frame_use_global && res_s7.frame_valid)

endmodule

/* design/global_motion_type_decider_core.sv */
// ----------------------------------------------------------------------------
// global_motion_type_decider_core
// Per-PU, per-macroblock and per-frame global motion decisions.
// ----------------------------------------------------------------------------
// Usage:
//  - in channel (in_valid/in_ready): one word per motion block, PU order inside
//    each macroblock. Words with boundary inside a PU only accumulate.
//  - out channel (out_valid/out_ready): one result word per input word that
//    ends a PU, in input order.
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//    write only while the block is idle.
//  - Throughput: one word per cycle sustained while out_ready stays high.
//  - Each PU word is written into a 4-entry PU queue; behind it the back end is
//    a 7-stage pipeline (rounding, difference, square, threshold compare,
//    counters, ratio multiply, verdict) ending in the out_valid register.
//  - When the receiver stalls, the back pipeline holds; the queue takes up to
//    four more PU words, then in_ready drops. Words inside a PU are held too.
//  - Reset clears the sums, all counters and the queue, and loads the
//    threshold 16, macroblock-based verdict and ratio 9.
// ----------------------------------------------------------------------------
module global_motion_type_decider_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          pu_mode,
	input  logic [1:0]                          pu_depth,
	input  logic [gmtd_pkg::VECTOR_BITS-1:0]    local1_x,
	input  logic [gmtd_pkg::VECTOR_BITS-1:0]    local1_y,
	input  logic [gmtd_pkg::VECTOR_BITS-1:0]    local2_x,
	input  logic [gmtd_pkg::VECTOR_BITS-1:0]    local2_y,
	input  logic [gmtd_pkg::VECTOR_BITS-1:0]    glob1_x,
	input  logic [gmtd_pkg::VECTOR_BITS-1:0]    glob1_y,
	input  logic [gmtd_pkg::VECTOR_BITS-1:0]    glob2_x,
	input  logic [gmtd_pkg::VECTOR_BITS-1:0]    glob2_y,
	input  logic [1:0]                          boundary,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                pu_inter,
	output logic                                pu_use_global,
	output logic                                mb_valid,
	output logic                                mb_use_global,
	output logic                                frame_valid,
	output logic                                frame_use_global,
	output logic                                frame_global_only,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gmtd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gmtd_pkg::CFG_DAT_W-1:0]      cfg_data
);

	gmtd_pkg::cfg_t      cfg_q;
	gmtd_pkg::entry_t    push_entry;
	gmtd_pkg::entry_t    head;
	gmtd_pkg::q_status_t qs;
	gmtd_pkg::res_t      res;
	logic                push;
	logic                pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr   <= gmtd_pkg::THR_RESET;
			cfg_q.by_mb <= gmtd_pkg::BY_MB_RESET;
			cfg_q.ratio <= gmtd_pkg::RATIO_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				gmtd_pkg::CFG_THRESHOLD: cfg_q.thr   <= cfg_data[gmtd_pkg::THR_W-1:0];
				gmtd_pkg::CFG_BY_MB:     cfg_q.by_mb <= cfg_data[0];
				gmtd_pkg::CFG_RATIO:     cfg_q.ratio <= cfg_data[gmtd_pkg::RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	gmtd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pu_mode     (pu_mode),
		.pu_depth    (pu_depth),
		.local1_x    (local1_x),
		.local1_y    (local1_y),
		.local2_x    (local2_x),
		.local2_y    (local2_y),
		.glob1_x     (glob1_x),
		.glob1_y     (glob1_y),
		.glob2_x     (glob2_x),
		.glob2_y     (glob2_y),
		.boundary    (boundary),
		.qs          (qs),
		.push        (push),
		.push_entry  (push_entry)
	);

	gmtd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qs         (qs)
	);

	gmtd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.qs        (qs),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign pu_inter          = res.pu_inter;
	assign pu_use_global     = res.pu_use_global;
	assign mb_valid          = res.mb_valid;
	assign mb_use_global     = res.mb_use_global;
	assign frame_valid       = res.frame_valid;
	assign frame_use_global  = res.frame_use_global;
	assign frame_global_only = res.frame_global_only;

endmodule

/* tb/tb_global_motion_type_decider_core.sv */
// ----------------------------------------------------------------------------
// tb_global_motion_type_decider_core
// Self-checking bench: a directed table of words, then random frames built
// from well-formed macroblocks with some malformed ones mixed in. Every
// accepted input word runs through a PU/macroblock/frame decision predictor.
// Each result word is checked field by field against the oldest expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_global_motion_type_decider_core;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 24;
	localparam int PHASE_WORDS  = 220;
	localparam int NUM_PHASES   = 6;
	localparam int VB           = gmtd_pkg::VECTOR_BITS;

	typedef struct packed {
		gmtd_pkg::mode_t                mode;
		logic [1:0]                     depth;
		logic signed [VB-1:0]           l1x, l1y, l2x, l2y;
		logic signed [VB-1:0]           g1x, g1y, g2x, g2y;
		gmtd_pkg::bnd_t                 bnd;
	} mv_word_t;

	typedef struct {
		mv_word_t       w;
		bit             chk;
		gmtd_pkg::res_t exp;
	} dir_row_t;

	logic                                clk;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_ready;
	logic [1:0]                          pu_mode;
	logic [1:0]                          pu_depth;
	logic [VB-1:0]                       local1_x, local1_y, local2_x, local2_y;
	logic [VB-1:0]                       glob1_x, glob1_y, glob2_x, glob2_y;
	logic [1:0]                          boundary;
	logic                                out_valid;
	logic                                out_ready;
	logic                                pu_inter, pu_use_global, mb_valid, mb_use_global;
	logic                                frame_valid, frame_use_global, frame_global_only;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [gmtd_pkg::CFG_IDX_W-1:0]      cfg_index;
	logic [gmtd_pkg::CFG_DAT_W-1:0]      cfg_data;

	// typed-in expectation travelling with the driven word
	bit                                  in_chk;
	gmtd_pkg::res_t                      in_exp;

	global_motion_type_decider_core uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.pu_mode           (pu_mode),
		.pu_depth          (pu_depth),
		.local1_x          (local1_x),
		.local1_y          (local1_y),
		.local2_x          (local2_x),
		.local2_y          (local2_y),
		.glob1_x           (glob1_x),
		.glob1_y           (glob1_y),
		.glob2_x           (glob2_x),
		.glob2_y           (glob2_y),
		.boundary          (boundary),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.pu_inter          (pu_inter),
		.pu_use_global     (pu_use_global),
		.mb_valid          (mb_valid),
		.mb_use_global     (mb_use_global),
		.frame_valid       (frame_valid),
		.frame_use_global  (frame_use_global),
		.frame_global_only (frame_global_only),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	// predictor copy of the registers and the accumulators
	logic [gmtd_pkg::THR_W-1:0]          thr_cfg   = gmtd_pkg::THR_RESET;
	logic                                by_mb_cfg = gmtd_pkg::BY_MB_RESET;
	logic [gmtd_pkg::RATIO_W-1:0]        ratio_cfg = gmtd_pkg::RATIO_RESET;
	logic signed [gmtd_pkg::SUM_W-1:0]   gsum[4]   = '{default: '0};
	int                                  mb_glob_pus = 0, mb_loc_pus = 0;
	int                                  fr_glob_mbs = 0, fr_loc_mbs = 0;
	int                                  fr_glob_blks = 0, fr_loc_blks = 0;

	gmtd_pkg::res_t                      pending_decisions[$];
	dir_row_t                            dir_rows[$];
	int                                  mismatch_count = 0;
	int                                  cycle_count = 0;
	int                                  words_sent = 0;
	int                                  burst_left = 0;
	int                                  cur_prof = 0;

	string res_names[7] = '{"frame_global_only", "frame_use_global", "frame_valid",
		"mb_use_global", "mb_valid", "pu_use_global", "pu_inter"};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("%0d ns: %s", $time, msg);
	endtask

	function automatic longint sq_dist(input longint mx, my, gx, gy);
		return (mx - gx) * (mx - gx) + (my - gy) * (my - gy);
	endfunction

	function automatic int sat_inc(input int v, input int step, input int lim);
		return (v + step > lim) ? lim : v + step;
	endfunction

	// one word into the decision predictor; returns 1 when it yields a result
	function automatic bit decide_word(input mv_word_t w, output gmtd_pkg::res_t r);
		logic signed [VB-1:0] g[4];
		longint mean[4];
		longint v, gc, lc;
		int     dep, sh, nblk;
		bit     ok1, ok2, pu_g;

		g = '{w.g1x, w.g1y, w.g2x, w.g2y};
		r = '0;
		for (int k = 0; k < 4; k++)
			gsum[k] = gsum[k] + g[k];
		if (w.bnd == gmtd_pkg::BND_INSIDE)
			return 1'b0;

		dep  = (w.depth > 2) ? 2 : int'(w.depth);
		sh   = 2 * (2 - dep);
		nblk = 1 << sh;
		for (int k = 0; k < 4; k++) begin
			v = longint'(gsum[k]);
			mean[k] = (sh == 0) ? v : (v + (longint'(1) << (sh - 1))) >>> sh;
			gsum[k] = '0;
		end

		if (w.mode != gmtd_pkg::MODE_INTRA) begin
			ok1 = sq_dist(longint'(w.l1x), longint'(w.l1y), mean[0], mean[1])
				<= longint'(thr_cfg);
			ok2 = sq_dist(longint'(w.l2x), longint'(w.l2y), mean[2], mean[3])
				<= longint'(thr_cfg);
			case (w.mode)
				gmtd_pkg::MODE_REF1: pu_g = ok1;
				gmtd_pkg::MODE_REF2: pu_g = ok2;
				default:             pu_g = ok1 && ok2;
			endcase
			r.pu_inter      = 1'b1;
			r.pu_use_global = pu_g;
			if (pu_g) begin
				mb_glob_pus  = sat_inc(mb_glob_pus, 1, int'(gmtd_pkg::PU_CNT_MAX));
				fr_glob_blks = sat_inc(fr_glob_blks, nblk,
					gmtd_pkg::BLOCKS_PER_MB * gmtd_pkg::MAX_MACROBLOCKS);
			end else begin
				mb_loc_pus  = sat_inc(mb_loc_pus, 1, int'(gmtd_pkg::PU_CNT_MAX));
				fr_loc_blks = sat_inc(fr_loc_blks, nblk,
					gmtd_pkg::BLOCKS_PER_MB * gmtd_pkg::MAX_MACROBLOCKS);
			end
		end

		if (w.bnd == gmtd_pkg::BND_MB || w.bnd == gmtd_pkg::BND_FRAME) begin
			if (mb_glob_pus + mb_loc_pus > 0) begin
				r.mb_valid = 1'b1;
				if (mb_loc_pus == 0) begin
					r.mb_use_global = 1'b1;
					fr_glob_mbs = sat_inc(fr_glob_mbs, 1, gmtd_pkg::MAX_MACROBLOCKS);
				end else begin
					fr_loc_mbs = sat_inc(fr_loc_mbs, 1, gmtd_pkg::MAX_MACROBLOCKS);
				end
			end
			mb_glob_pus = 0;
			mb_loc_pus  = 0;
		end

		if (w.bnd == gmtd_pkg::BND_FRAME) begin
			gc = by_mb_cfg ? fr_glob_mbs : fr_glob_blks;
			lc = by_mb_cfg ? fr_loc_mbs : fr_loc_blks;
			r.frame_valid = 1'b1;
			if (gc >= lc) begin
				r.frame_use_global  = 1'b1;
				r.frame_global_only = gc > longint'(ratio_cfg) * lc;
			end
			fr_glob_mbs  = 0;
			fr_loc_mbs   = 0;
			fr_glob_blks = 0;
			fr_loc_blks  = 0;
		end
		return 1'b1;
	endfunction

	// accepted words on both channels, sampled before this edge's updates
	mv_word_t       mon_w;
	gmtd_pkg::res_t mon_pred, mon_got, mon_exp;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				mon_w.mode  = gmtd_pkg::mode_t'(pu_mode);
				mon_w.depth = pu_depth;
				mon_w.l1x   = local1_x;
				mon_w.l1y   = local1_y;
				mon_w.l2x   = local2_x;
				mon_w.l2y   = local2_y;
				mon_w.g1x   = glob1_x;
				mon_w.g1y   = glob1_y;
				mon_w.g2x   = glob2_x;
				mon_w.g2y   = glob2_y;
				mon_w.bnd   = gmtd_pkg::bnd_t'(boundary);
				if (decide_word(mon_w, mon_pred))
					pending_decisions.push_back(in_chk ? in_exp : mon_pred);
			end
			if (out_valid && out_ready) begin
				mon_got = '{pu_inter, pu_use_global, mb_valid, mb_use_global,
					frame_valid, frame_use_global, frame_global_only};
				if (pending_decisions.size() == 0) begin
					report_mismatch("result word with no decision pending");
				end else begin
					mon_exp = pending_decisions.pop_front();
					for (int i = 0; i < 7; i++)
						if (mon_got[i] !== mon_exp[i])
							report_mismatch($sformatf("%s: got %b, expected %b",
								res_names[i], mon_got[i], mon_exp[i]));
				end
			end
		end
	end

	// receiver: segments of steady, random, mostly-ready or mostly-stalled
	initial begin
		int pat;
		int seg;

		out_ready <= 1'b0;
		forever begin
			pat = $urandom_range(0, 3);
			seg = $urandom_range(10, 200);
			repeat (seg) begin
				@(posedge clk);
				case (pat)
					0:       out_ready <= 1'b1;
					1:       out_ready <= 1'($urandom_range(0, 1));
					2:       out_ready <= ($urandom_range(0, 9) != 0);
					default: out_ready <= ($urandom_range(0, 19) == 0);
				endcase
			end
		end
	end

	task automatic put_word(input mv_word_t w, input bit chk, input gmtd_pkg::res_t e);
		int gap;

		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		in_valid    <= 1'b1;
		pu_mode     <= w.mode;
		pu_depth    <= w.depth;
		local1_x    <= w.l1x;
		local1_y    <= w.l1y;
		local2_x    <= w.l2x;
		local2_y    <= w.l2y;
		glob1_x     <= w.g1x;
		glob1_y     <= w.g1y;
		glob2_x     <= w.g2x;
		glob2_y     <= w.g2y;
		boundary    <= w.bnd;
		in_chk      <= chk;
		in_exp      <= e;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		words_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_decisions.size() != 0)
			@(posedge clk);
		// words inside a PU leave no result but may still be in flight
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input gmtd_pkg::cfg_idx_t idx,
			input logic [gmtd_pkg::CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			gmtd_pkg::CFG_THRESHOLD: thr_cfg   = val;
			gmtd_pkg::CFG_BY_MB:     by_mb_cfg = val[0];
			gmtd_pkg::CFG_RATIO:     ratio_cfg = val[gmtd_pkg::RATIO_W-1:0];
			default:                 ;
		endcase
	endtask

	task automatic add_row(input gmtd_pkg::mode_t m, input logic [1:0] d,
			input int l1x, l1y, l2x, l2y, g1x, g1y, g2x, g2y,
			input gmtd_pkg::bnd_t b, input bit chk, input gmtd_pkg::res_t e);
		dir_row_t row;

		row.w   = '{m, d, VB'(l1x), VB'(l1y), VB'(l2x), VB'(l2y),
			VB'(g1x), VB'(g1y), VB'(g2x), VB'(g2y), b};
		row.chk = chk;
		row.exp = e;
		dir_rows.push_back(row);
	endtask

	function automatic logic signed [VB-1:0] pick_base(input bit extreme);
		if (extreme || $urandom_range(0, 9) == 9)
			return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		if ($urandom_range(0, 9) < 7)
			return VB'(int'($urandom_range(0, 4000)) - 2000);
		return VB'($urandom);
	endfunction

	// offset of the PU vector from the blocks' global motion, per frame profile
	function automatic int pick_delta();
		int p;

		p = (cur_prof == 1) ? $urandom_range(0, 2) : cur_prof;
		case (p)
			0:       return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 6)) - 3;
			1:       return int'($urandom_range(0, 600)) - 300;
			default: return ($urandom_range(0, 4) == 0) ? int'($urandom)
				: int'($urandom_range(0, 2000)) - 1000;
		endcase
	endfunction

	task automatic send_pu(input logic [1:0] dfield, input int nitems,
			input gmtd_pkg::bnd_t last_bnd, input bit extreme);
		mv_word_t w;
		logic signed [VB-1:0] base[4];
		gmtd_pkg::mode_t m;
		int jit;

		m = gmtd_pkg::mode_t'($urandom_range(0, 3));
		for (int k = 0; k < 4; k++)
			base[k] = pick_base(extreme);
		case ($urandom_range(0, 3))
			0, 1:    jit = 0;
			2:       jit = 2;
			default: jit = 60;
		endcase
		for (int i = 0; i < nitems; i++) begin
			// fields other than the global vectors are noise until the PU ends
			w.mode  = gmtd_pkg::mode_t'($urandom_range(0, 3));
			w.depth = 2'($urandom_range(0, 3));
			w.l1x   = VB'($urandom);
			w.l1y   = VB'($urandom);
			w.l2x   = VB'($urandom);
			w.l2y   = VB'($urandom);
			w.g1x   = VB'(base[0] + int'($urandom_range(0, 2 * jit)) - jit);
			w.g1y   = VB'(base[1] + int'($urandom_range(0, 2 * jit)) - jit);
			w.g2x   = VB'(base[2] + int'($urandom_range(0, 2 * jit)) - jit);
			w.g2y   = VB'(base[3] + int'($urandom_range(0, 2 * jit)) - jit);
			w.bnd   = gmtd_pkg::BND_INSIDE;
			if (i == nitems - 1) begin
				w.mode  = m;
				w.depth = dfield;
				w.l1x   = VB'(base[0] + pick_delta());
				w.l1y   = VB'(base[1] + pick_delta());
				w.l2x   = VB'(base[2] + pick_delta());
				w.l2y   = VB'(base[3] + pick_delta());
				w.bnd   = last_bnd;
			end
			put_word(w, 1'b0, '0);
		end
	endtask

	task automatic send_macroblock(input gmtd_pkg::bnd_t end_bnd);
		int remaining;
		int d;
		int n;

		remaining = 16;
		while (remaining > 0) begin
			d = $urandom_range(0, 2);
			while ((16 >> (2 * d)) > remaining)
				d++;
			n = 16 >> (2 * d);
			remaining -= n;
			send_pu((d == 2 && $urandom_range(0, 7) == 0) ? 2'd3 : 2'(d), n,
				(remaining == 0) ? end_bnd : gmtd_pkg::BND_PU, 1'b0);
		end
	endtask

	// wrong block counts, sum wrap, PU counter saturation
	task automatic send_bad_macroblock(input gmtd_pkg::bnd_t end_bnd);
		int n;

		case ($urandom_range(0, 2))
			0: send_pu(2'($urandom_range(0, 3)), $urandom_range(17, 48), end_bnd, 1'b1);
			1: begin
				n = $urandom_range(30, 40);
				for (int i = 0; i < n; i++)
					send_pu(2'd2, 1, (i == n - 1) ? end_bnd : gmtd_pkg::BND_PU, 1'b0);
			end
			default: begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					send_pu(2'($urandom_range(0, 3)), $urandom_range(1, 20),
						(i == n - 1) ? end_bnd : gmtd_pkg::BND_PU, 1'b0);
			end
		endcase
	endtask

	task automatic send_frame();
		int n_mb;
		gmtd_pkg::bnd_t eb;

		n_mb = $urandom_range(1, 4);
		cur_prof = $urandom_range(0, 2);
		for (int i = 0; i < n_mb; i++) begin
			eb = (i == n_mb - 1) ? gmtd_pkg::BND_FRAME : gmtd_pkg::BND_MB;
			if ($urandom_range(0, 6) == 0)
				send_bad_macroblock(eb);
			else
				send_macroblock(eb);
		end
	endtask

	int phase_thr[NUM_PHASES]   = '{16, 0, 65535, 16, 1000, 0};
	int phase_by_mb[NUM_PHASES] = '{1, 1, 0, 0, 1, 0};
	int phase_ratio[NUM_PHASES] = '{9, 1, 255, 9, 2, 1};
	int phase_start;

	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		pu_mode     <= gmtd_pkg::MODE_INTRA;
		pu_depth    <= '0;
		local1_x    <= '0;
		local1_y    <= '0;
		local2_x    <= '0;
		local2_y    <= '0;
		glob1_x     <= '0;
		glob1_y     <= '0;
		glob2_x     <= '0;
		glob2_y     <= '0;
		boundary    <= gmtd_pkg::BND_INSIDE;
		in_chk      <= 1'b0;
		in_exp      <= '0;
		cfg_valid   <= 1'b0;
		cfg_index   <= gmtd_pkg::CFG_THRESHOLD;
		cfg_data    <= '0;

		// result fields: pu_inter pu_use_global mb_valid mb_use_global
		//                frame_valid frame_use_global frame_global_only
		// empty frame: global used, not only
		add_row(gmtd_pkg::MODE_INTRA, 2, 0, 0, 0, 0, 0, 0, 0, 0,
			gmtd_pkg::BND_FRAME, 1, 7'b0000110);
		add_row(gmtd_pkg::MODE_BOTH, 2, 0, 0, 0, 0, 0, 0, 0, 0,
			gmtd_pkg::BND_FRAME, 1, 7'b1111111);
		add_row(gmtd_pkg::MODE_REF1, 2, -32768, 32767, 0, 0, 32767, -32768, 0, 0,
			gmtd_pkg::BND_FRAME, 1, 7'b1010100);
		// squared distance exactly at, then just over, the threshold
		add_row(gmtd_pkg::MODE_REF1, 2, 4, 0, 0, 0, 0, 0, 0, 0,
			gmtd_pkg::BND_PU, 1, 7'b1100000);
		add_row(gmtd_pkg::MODE_REF2, 2, 32767, 32767, 4, 1, 0, 0, 0, 0,
			gmtd_pkg::BND_PU, 1, 7'b1000000);
		add_row(gmtd_pkg::MODE_INTRA, 2, 0, 0, 0, 0, 0, 0, 0, 0,
			gmtd_pkg::BND_MB, 1, 7'b0010000);
		add_row(gmtd_pkg::MODE_REF2, 2, 32767, 32767, -32768, -32768, -32768, -32768,
			-32768, -32768, gmtd_pkg::BND_MB, 1, 7'b1111000);
		add_row(gmtd_pkg::MODE_BOTH, 2, 32767, 32767, 100, 0, 32767, 32767, 0, 0,
			gmtd_pkg::BND_FRAME, 1, 7'b1010100);
		// round half up on +0.5 and -0.5; operands from the closing word only
		add_row(gmtd_pkg::MODE_INTRA, 0, 9, 9, 9, 9, 1, -1, 3, -32768,
			gmtd_pkg::BND_INSIDE, 0, '0);
		add_row(gmtd_pkg::MODE_INTRA, 0, 9, 9, 9, 9, 0, -1, 3, -32768,
			gmtd_pkg::BND_INSIDE, 0, '0);
		add_row(gmtd_pkg::MODE_INTRA, 0, 9, 9, 9, 9, 0, 0, 3, -32768,
			gmtd_pkg::BND_INSIDE, 0, '0);
		add_row(gmtd_pkg::MODE_BOTH, 1, 1, 0, 3, -32768, 1, 0, 3, -32768,
			gmtd_pkg::BND_PU, 0, '0);
		// split depth three acts as one block
		add_row(gmtd_pkg::MODE_REF1, 3, 5, 9, 0, 0, 5, 5, 0, 0,
			gmtd_pkg::BND_PU, 0, '0);
		// too few blocks for a depth-zero PU
		add_row(gmtd_pkg::MODE_INTRA, 3, 0, 0, 0, 0, 32767, -32768, 7, -7,
			gmtd_pkg::BND_INSIDE, 0, '0);
		add_row(gmtd_pkg::MODE_BOTH, 0, 4096, -4096, 1, -1, 32767, -32768, 7, -7,
			gmtd_pkg::BND_MB, 0, '0);
		add_row(gmtd_pkg::MODE_INTRA, 2, 0, 0, 0, 0, 0, 0, 0, 0,
			gmtd_pkg::BND_FRAME, 0, '0);

		phase_thr[5]   = $urandom_range(0, 65535);
		phase_by_mb[5] = $urandom_range(0, 1);
		phase_ratio[5] = $urandom_range(1, 255);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			put_word(dir_rows[i].w, dir_rows[i].chk, dir_rows[i].exp);

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0) begin
				drain_results();
				write_reg(gmtd_pkg::CFG_THRESHOLD, gmtd_pkg::CFG_DAT_W'(phase_thr[p]));
				write_reg(gmtd_pkg::CFG_BY_MB, gmtd_pkg::CFG_DAT_W'(phase_by_mb[p]));
				write_reg(gmtd_pkg::CFG_RATIO, gmtd_pkg::CFG_DAT_W'(phase_ratio[p]));
			end
			phase_start = words_sent;
			while (words_sent - phase_start < PHASE_WORDS)
				send_frame();
		end
		drain_results();

		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* global_motion_type_decider_core.f */
+incdir+design
design/gmtd_pkg.sv
design/gmtd_front.sv
design/gmtd_queue.sv
design/gmtd_back.sv
design/global_motion_type_decider_core.sv
tb/tb_global_motion_type_decider_core.sv
